[src/dkef_pkg.sv]
// dkef_pkg: shared types, constants and reset values of the dual-kernel edge filter.
// No dependencies; every other file uses it by scoped names.
package dkef_pkg;

   localparam int DEF_MAX_LINE_BYTES  = 4096;
   localparam int DEF_MAX_PIXEL_BYTES = 4;

   localparam int DATA_W    = 8;
   localparam int KERN_W    = 36;
   localparam int COEF_W    = 4;
   localparam int NUM_COEF  = 9;
   localparam int DIM_W     = 13;
   localparam int PB_W      = 3;
   localparam int MAX_DIM   = 4096;
   localparam int CSR_IDX_W = 3;

   localparam int PIPE_STAGES    = 4;
   localparam int RSP_FIFO_DEPTH = 8;

   localparam int PROD_W = DATA_W + 1 + COEF_W;
   localparam int SUM_W  = 16;

   localparam logic [KERN_W-1:0] KERNEL_A_RESET    = 36'd4848619503;
   localparam logic [KERN_W-1:0] KERNEL_B_RESET    = 36'd4548780303;
   localparam logic [DIM_W-1:0]  LINE_BYTES_RESET  = 13'd640;
   localparam logic [PB_W-1:0]   PIXEL_BYTES_RESET = 3'd1;
   localparam logic [DIM_W-1:0]  WIDTH_RESET       = 13'd640;
   localparam logic [DIM_W-1:0]  HEIGHT_RESET      = 13'd480;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KERNEL_A     = 3'd0,
      CSR_KERNEL_B     = 3'd1,
      CSR_LINE_BYTES   = 3'd2,
      CSR_PIXEL_BYTES  = 3'd3,
      CSR_WIDTH_PIXELS = 3'd4,
      CSR_HEIGHT_ROWS  = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_byte;
      logic              flush;
   } req_payload_type;

   typedef struct packed {
      logic [DATA_W-1:0] result_byte;
      logic              last_of_frame;
   } rsp_payload_type;

   typedef struct packed {
      logic emit;
      logic last;
      logic interior;
   } stage_ctrl_type;

endpackage

[src/dkef_line_buffer.sv]
// dkef_line_buffer: two-row line memory (read, then write back shifted) and
// per-row tap lines that form the 3x3 same-channel window. Uses dkef_pkg.
module dkef_line_buffer #(
   parameter int MAX_LINE_BYTES  = dkef_pkg::DEF_MAX_LINE_BYTES,
   parameter int MAX_PIXEL_BYTES = dkef_pkg::DEF_MAX_PIXEL_BYTES
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [dkef_pkg::DATA_W-1:0]                   in_byte,
   input  logic [$clog2(MAX_LINE_BYTES)-1:0]             in_addr,
   input  dkef_pkg::stage_ctrl_type                      in_ctrl,
   input  logic [dkef_pkg::PB_W-1:0]                     pixel_bytes,
   output logic                                          win_valid,
   output logic [dkef_pkg::NUM_COEF-1:0][dkef_pkg::DATA_W-1:0] win,
   output dkef_pkg::stage_ctrl_type                      win_ctrl
);

   localparam int AW   = $clog2(MAX_LINE_BYTES);
   localparam int TAPS = 2 * MAX_PIXEL_BYTES + 1;
   localparam int DW   = dkef_pkg::DATA_W;

   // entry holds {byte two lines back, byte one line back} for a column
   logic [2*DW-1:0] line_mem [MAX_LINE_BYTES];

   logic            s1_valid_ff;
   logic [DW-1:0]   s1_byte_ff;
   logic [AW-1:0]   s1_addr_ff;
   dkef_pkg::stage_ctrl_type s1_ctrl_ff;
   logic [2*DW-1:0] rd_ff;
   logic [2*DW-1:0] wr_data;
   logic            fwd;

   logic [DW-1:0]   sr_ff [3][TAPS];
   logic [DW-1:0]   row_new [3];
   logic            win_valid_ff;
   dkef_pkg::stage_ctrl_type win_ctrl_ff;

   logic [DW-1:0]   tap_mid [3];
   logic [DW-1:0]   tap_far [3];

   assign wr_data = {rd_ff[DW-1:0], s1_byte_ff};
   assign fwd     = s1_valid_ff && (s1_addr_ff == in_addr);

   assign row_new[0] = rd_ff[2*DW-1:DW];
   assign row_new[1] = rd_ff[DW-1:0];
   assign row_new[2] = s1_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= in_valid;
         win_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         rd_ff      <= fwd ? wr_data : line_mem[in_addr];
         s1_byte_ff <= in_byte;
         s1_addr_ff <= in_addr;
         s1_ctrl_ff <= in_ctrl;
      end
      if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            sr_ff[r][0] <= row_new[r];
            for (int i = 1; i < TAPS; i++) begin
               sr_ff[r][i] <= sr_ff[r][i-1];
            end
         end
      end
      win_ctrl_ff <= s1_ctrl_ff;
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         tap_mid[r] = sr_ff[r][1];
         tap_far[r] = sr_ff[r][2];
         for (int j = 1; j <= MAX_PIXEL_BYTES; j++) begin
            if (pixel_bytes == dkef_pkg::PB_W'(j)) begin
               tap_mid[r] = sr_ff[r][j];
               tap_far[r] = sr_ff[r][2*j];
            end
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win[3*r]     = tap_far[r];
         win[3*r + 1] = tap_mid[r];
         win[3*r + 2] = sr_ff[r][0];
      end
   end

   assign win_valid = win_valid_ff;
   assign win_ctrl  = win_ctrl_ff;

endmodule

[src/dkef_kernel_mac.sv]
// dkef_kernel_mac: products, kernel sums and magnitude add for both kernels,
// two register stages. Uses dkef_pkg.
module dkef_kernel_mac (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          in_valid,
   input  logic [dkef_pkg::NUM_COEF-1:0][dkef_pkg::DATA_W-1:0] win,
   input  dkef_pkg::stage_ctrl_type                      in_ctrl,
   input  logic [dkef_pkg::KERN_W-1:0]                   kernel_a,
   input  logic [dkef_pkg::KERN_W-1:0]                   kernel_b,
   output logic                                          push_valid,
   output dkef_pkg::rsp_payload_type                     push_data
);

   localparam int NC  = dkef_pkg::NUM_COEF;
   localparam int CW  = dkef_pkg::COEF_W;
   localparam int PW  = dkef_pkg::PROD_W;
   localparam int SW  = dkef_pkg::SUM_W;
   localparam int DW  = dkef_pkg::DATA_W;

   logic signed [PW-1:0] prod_a_in [NC];
   logic signed [PW-1:0] prod_b_in [NC];
   logic signed [PW-1:0] prod_a_ff [NC];
   logic signed [PW-1:0] prod_b_ff [NC];
   logic                 s3_valid_ff;
   dkef_pkg::stage_ctrl_type s3_ctrl_ff;
   logic [DW-1:0]        s3_center_ff;

   logic signed [SW-1:0] sum_a_in;
   logic signed [SW-1:0] sum_b_in;
   logic signed [SW-1:0] sum_a_ff;
   logic signed [SW-1:0] sum_b_ff;
   logic                 s4_valid_ff;
   dkef_pkg::stage_ctrl_type s4_ctrl_ff;
   logic [DW-1:0]        s4_center_ff;

   logic [SW-1:0]        mag_a;
   logic [SW-1:0]        mag_b;
   logic [SW-1:0]        mag_total;

   always_comb begin
      for (int k = 0; k < NC; k++) begin
         prod_a_in[k] = $signed({1'b0, win[k]}) * $signed(kernel_a[CW*k +: CW]);
         prod_b_in[k] = $signed({1'b0, win[k]}) * $signed(kernel_b[CW*k +: CW]);
      end
   end

   always_comb begin
      sum_a_in = '0;
      sum_b_in = '0;
      for (int k = 0; k < NC; k++) begin
         sum_a_in = sum_a_in + SW'(prod_a_ff[k]);
         sum_b_in = sum_b_in + SW'(prod_b_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= in_valid;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NC; k++) begin
         prod_a_ff[k] <= prod_a_in[k];
         prod_b_ff[k] <= prod_b_in[k];
      end
      s3_ctrl_ff   <= in_ctrl;
      s3_center_ff <= win[4];
      sum_a_ff     <= sum_a_in;
      sum_b_ff     <= sum_b_in;
      s4_ctrl_ff   <= s3_ctrl_ff;
      s4_center_ff <= s3_center_ff;
   end

   assign mag_a     = sum_a_ff[SW-1] ? SW'(-sum_a_ff) : SW'(sum_a_ff);
   assign mag_b     = sum_b_ff[SW-1] ? SW'(-sum_b_ff) : SW'(sum_b_ff);
   assign mag_total = mag_a + mag_b;

   assign push_valid              = s4_valid_ff && s4_ctrl_ff.emit;
   assign push_data.result_byte   = s4_ctrl_ff.interior ? mag_total[DW-1:0] : s4_center_ff;
   assign push_data.last_of_frame = s4_ctrl_ff.last;

endmodule

[src/dkef_rsp_fifo.sv]
// dkef_rsp_fifo: result queue between the filter pipeline and the rsp channel.
// Uses dkef_pkg; depth must be a power of two.
module dkef_rsp_fifo #(
   parameter int DEPTH = dkef_pkg::RSP_FIFO_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  dkef_pkg::rsp_payload_type     push_data,
   output logic                          pop_valid,
   input  logic                          pop_ready,
   output dkef_pkg::rsp_payload_type     pop_data,
   output logic [$clog2(DEPTH+1)-1:0]    count
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH+1);

   dkef_pkg::rsp_payload_type fifo_mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && pop_ready;
   assign pop_data  = fifo_mem[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push_valid) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         fifo_mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/dual_kernel_3x3_edge_filter.sv]
// Dual-kernel 3x3 edge filter. Result beat for frame byte q starts when the beat with
// byte q + line_bytes + pixel_bytes is accepted, passing the line buffer, product, sum
// and queue registers to rsp; a frame closes with line_bytes + pixel_bytes flush beats.
// Throughput: one beat per cycle, one line memory read and write-back per byte; req_ready
// is low only in reset or while queued plus in-flight beats reach the 8-entry queue depth.
// Reset (synchronous): registers return to the Sobel pair and 640x480x1, positions
// and queue clear; the line memory is not cleared.
module dual_kernel_3x3_edge_filter #(
   parameter int MAX_LINE_BYTES  = dkef_pkg::DEF_MAX_LINE_BYTES,
   parameter int MAX_PIXEL_BYTES = dkef_pkg::DEF_MAX_PIXEL_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  dkef_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output dkef_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dkef_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dkef_pkg::KERN_W-1:0]         csr_data
);

   localparam int AW    = $clog2(MAX_LINE_BYTES);
   localparam int LCW   = $clog2(MAX_LINE_BYTES + 1);
   localparam int LGW   = LCW + 1;
   localparam int DW    = dkef_pkg::DIM_W;
   localparam int PBW   = dkef_pkg::PB_W;
   localparam int WIDE  = ((LCW > DW) ? LCW : DW) + 2;
   localparam int PS    = dkef_pkg::PIPE_STAGES;
   localparam int FD    = dkef_pkg::RSP_FIFO_DEPTH;
   localparam int FCW   = $clog2(FD + 1);
   localparam int FSW   = FCW + 1;

   logic [dkef_pkg::KERN_W-1:0] kernel_a_ff, kernel_b_ff;
   logic [DW-1:0]  line_bytes_ff, width_pixels_ff, height_rows_ff;
   logic [PBW-1:0] pixel_bytes_ff;

   logic [LCW-1:0] line_c;
   logic [PBW-1:0] pb_c;
   logic [DW-1:0]  wp_c;
   logic [DW-1:0]  h_c;
   logic [LGW-1:0] lag;

   logic [AW-1:0]  s_col_ff, s_col_in;
   logic [DW-1:0]  in_row_ff, in_row_in;
   logic           in_done_ff, in_done_in;
   logic [LGW-1:0] gap_ff, gap_in;
   logic [DW-1:0]  o_row_ff, o_row_in;
   logic [AW-1:0]  o_colb_ff, o_colb_in;
   logic [PBW-1:0] o_ch_ff, o_ch_in;
   logic [AW-1:0]  o_pix_ff, o_pix_in;
   logic [AW-1:0]  o_col_ff, o_col_in;
   logic [PS-1:0]  pipe_ff, pipe_in;

   logic           accept;
   logic           counted;
   logic           s_eol;
   logic           o_eol;
   dkef_pkg::stage_ctrl_type ctrl;

   logic           win_valid;
   logic [dkef_pkg::NUM_COEF-1:0][dkef_pkg::DATA_W-1:0] win;
   dkef_pkg::stage_ctrl_type win_ctrl;
   logic           push_valid;
   dkef_pkg::rsp_payload_type push_data;
   logic [FCW-1:0] fifo_count;
   logic [FSW-1:0] occupancy;

   // configuration
   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_a_ff     <= dkef_pkg::KERNEL_A_RESET;
         kernel_b_ff     <= dkef_pkg::KERNEL_B_RESET;
         line_bytes_ff   <= dkef_pkg::LINE_BYTES_RESET;
         pixel_bytes_ff  <= dkef_pkg::PIXEL_BYTES_RESET;
         width_pixels_ff <= dkef_pkg::WIDTH_RESET;
         height_rows_ff  <= dkef_pkg::HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            dkef_pkg::CSR_KERNEL_A:     kernel_a_ff     <= csr_data;
            dkef_pkg::CSR_KERNEL_B:     kernel_b_ff     <= csr_data;
            dkef_pkg::CSR_LINE_BYTES:   line_bytes_ff   <= csr_data[DW-1:0];
            dkef_pkg::CSR_PIXEL_BYTES:  pixel_bytes_ff  <= csr_data[PBW-1:0];
            dkef_pkg::CSR_WIDTH_PIXELS: width_pixels_ff <= csr_data[DW-1:0];
            dkef_pkg::CSR_HEIGHT_ROWS:  height_rows_ff  <= csr_data[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   // clamped geometry
   always_comb begin
      if (line_bytes_ff < DW'(3)) begin
         line_c = LCW'(3);
      end else if (line_bytes_ff > MAX_LINE_BYTES) begin
         line_c = LCW'(MAX_LINE_BYTES);
      end else begin
         line_c = LCW'(line_bytes_ff);
      end
      if (pixel_bytes_ff == '0) begin
         pb_c = PBW'(1);
      end else if (pixel_bytes_ff > MAX_PIXEL_BYTES) begin
         pb_c = PBW'(MAX_PIXEL_BYTES);
      end else begin
         pb_c = pixel_bytes_ff;
      end
      if (width_pixels_ff == '0) begin
         wp_c = DW'(1);
      end else if (width_pixels_ff > dkef_pkg::MAX_DIM) begin
         wp_c = DW'(dkef_pkg::MAX_DIM);
      end else begin
         wp_c = width_pixels_ff;
      end
      if (height_rows_ff == '0) begin
         h_c = DW'(1);
      end else if (height_rows_ff > dkef_pkg::MAX_DIM) begin
         h_c = DW'(dkef_pkg::MAX_DIM);
      end else begin
         h_c = height_rows_ff;
      end
   end

   assign lag = LGW'(line_c) + LGW'(pb_c);

   // input side
   assign occupancy = FSW'(fifo_count) + FSW'($countones(pipe_ff));
   assign req_ready = !reset && (occupancy < FSW'(FD));
   assign accept    = req_valid && req_ready;
   assign counted   = accept && !(req_payload.flush && !in_done_ff);

   assign s_eol = (LCW'(s_col_ff) == line_c - LCW'(1));
   assign o_eol = (LCW'(o_colb_ff) == line_c - LCW'(1));

   always_comb begin
      ctrl.emit     = (gap_ff == lag);
      ctrl.last     = ctrl.emit && (o_row_ff == h_c - DW'(1)) && o_eol;
      ctrl.interior = (o_row_ff != '0)
                   && (WIDE'(o_row_ff) + WIDE'(1) < WIDE'(h_c))
                   && (o_col_ff != '0)
                   && (WIDE'(o_col_ff) + WIDE'(2) <= WIDE'(wp_c))
                   && (WIDE'(o_pix_ff) + WIDE'({pb_c, 1'b0}) <= WIDE'(line_c));
   end

   always_comb begin
      s_col_in   = s_col_ff;
      in_row_in  = in_row_ff;
      in_done_in = in_done_ff;
      gap_in     = gap_ff;
      o_row_in   = o_row_ff;
      o_colb_in  = o_colb_ff;
      o_ch_in    = o_ch_ff;
      o_pix_in   = o_pix_ff;
      o_col_in   = o_col_ff;
      pipe_in    = {pipe_ff[PS-2:0], counted && ctrl.emit};
      if (counted) begin
         s_col_in = s_eol ? '0 : s_col_ff + AW'(1);
         if (!in_done_ff && s_eol) begin
            in_row_in = in_row_ff + DW'(1);
            if (in_row_ff == h_c - DW'(1)) begin
               in_done_in = 1'b1;
            end
         end
         if (ctrl.emit) begin
            if (o_eol) begin
               o_colb_in = '0;
               o_ch_in   = '0;
               o_pix_in  = '0;
               o_col_in  = '0;
               o_row_in  = o_row_ff + DW'(1);
            end else begin
               o_colb_in = o_colb_ff + AW'(1);
               if (o_ch_ff == pb_c - PBW'(1)) begin
                  o_ch_in  = '0;
                  o_pix_in = o_colb_ff + AW'(1);
                  o_col_in = o_col_ff + AW'(1);
               end else begin
                  o_ch_in = o_ch_ff + PBW'(1);
               end
            end
         end else begin
            gap_in = gap_ff + LGW'(1);
         end
         if (ctrl.last) begin
            s_col_in   = '0;
            in_row_in  = '0;
            in_done_in = 1'b0;
            gap_in     = '0;
            o_row_in   = '0;
            o_colb_in  = '0;
            o_ch_in    = '0;
            o_pix_in   = '0;
            o_col_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_col_ff   <= '0;
         in_row_ff  <= '0;
         in_done_ff <= 1'b0;
         gap_ff     <= '0;
         o_row_ff   <= '0;
         o_colb_ff  <= '0;
         o_ch_ff    <= '0;
         o_pix_ff   <= '0;
         o_col_ff   <= '0;
         pipe_ff    <= '0;
      end else begin
         s_col_ff   <= s_col_in;
         in_row_ff  <= in_row_in;
         in_done_ff <= in_done_in;
         gap_ff     <= gap_in;
         o_row_ff   <= o_row_in;
         o_colb_ff  <= o_colb_in;
         o_ch_ff    <= o_ch_in;
         o_pix_ff   <= o_pix_in;
         o_col_ff   <= o_col_in;
         pipe_ff    <= pipe_in;
      end
   end

   dkef_line_buffer #(
      .MAX_LINE_BYTES  (MAX_LINE_BYTES),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_line_buffer (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (counted),
      .in_byte     (req_payload.data_byte),
      .in_addr     (s_col_ff),
      .in_ctrl     (ctrl),
      .pixel_bytes (pb_c),
      .win_valid   (win_valid),
      .win         (win),
      .win_ctrl    (win_ctrl)
   );

   dkef_kernel_mac u_kernel_mac (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (win_valid),
      .win        (win),
      .in_ctrl    (win_ctrl),
      .kernel_a   (kernel_a_ff),
      .kernel_b   (kernel_b_ff),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   dkef_rsp_fifo #(
      .DEPTH (FD)
   ) u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (rsp_valid),
      .pop_ready  (rsp_ready),
      .pop_data   (rsp_payload),
      .count      (fifo_count)
   );

endmodule

[src/dkef_checker.sv]
// dkef_checker: port-level checks of the edge filter, bound to the top level.
// Uses dkef_pkg; sees only the top-level ports.
module dkef_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input dkef_pkg::rsp_payload_type       rsp_payload,
   input logic                            csr_ready
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   // queue is empty right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

   // nothing is taken while in reset
   assert property (@(posedge clock)
      reset |-> !req_ready && !csr_ready)
      else $error("ready high during reset");

   // a result appears only after the pipeline latency of an accepted beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 5))
      else $error("rsp beat without matching req beat");

endmodule

bind dual_kernel_3x3_edge_filter dkef_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_ready   (csr_ready)
);

[tb/dkef_edge_checker.sv]
`timescale 1ns / 1ps
// dkef_edge_checker: watches the request, result and register channels of the edge
// filter, predicts every result beat and compares it. Depends on dkef_pkg only.
module dkef_edge_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  dkef_pkg::req_payload_type      req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  dkef_pkg::rsp_payload_type      rsp_payload,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [dkef_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [dkef_pkg::KERN_W-1:0]    csr_data,
   output int                             pending_count,
   output int                             error_count
);

   localparam int RING_DEPTH =
      2 * (dkef_pkg::DEF_MAX_LINE_BYTES + dkef_pkg::DEF_MAX_PIXEL_BYTES) + 1;
   localparam int MIN_LINE_BYTES = 3;

   logic [dkef_pkg::KERN_W-1:0] kern_a;
   logic [dkef_pkg::KERN_W-1:0] kern_b;
   logic [dkef_pkg::DIM_W-1:0]  line_reg;
   logic [dkef_pkg::PB_W-1:0]   pix_reg;
   logic [dkef_pkg::DIM_W-1:0]  width_reg;
   logic [dkef_pkg::DIM_W-1:0]  height_reg;
   logic [dkef_pkg::DATA_W-1:0] byte_ring [RING_DEPTH];
   int unsigned                 in_pos;
   int unsigned                 out_pos;
   int unsigned                 result_beats;
   dkef_pkg::rsp_payload_type   expected_bytes [$];
   int                          mismatches = 0;

   assign error_count = mismatches;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int tap(logic [dkef_pkg::KERN_W-1:0] kernel, int k);
      logic signed [dkef_pkg::COEF_W-1:0] c;
      c = kernel[dkef_pkg::COEF_W*k +: dkef_pkg::COEF_W];
      return int'(c);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatches < 100)
         $display("%0t: result beat %0d: %s", $time, result_beats, what);
      mismatches++;
   endtask

   task automatic apply_register(logic [dkef_pkg::CSR_IDX_W-1:0] index,
                                 logic [dkef_pkg::KERN_W-1:0] value);
      case (index)
         dkef_pkg::CSR_KERNEL_A:     kern_a = value;
         dkef_pkg::CSR_KERNEL_B:     kern_b = value;
         dkef_pkg::CSR_LINE_BYTES:   line_reg = value[dkef_pkg::DIM_W-1:0];
         dkef_pkg::CSR_PIXEL_BYTES:  pix_reg = value[dkef_pkg::PB_W-1:0];
         dkef_pkg::CSR_WIDTH_PIXELS: width_reg = value[dkef_pkg::DIM_W-1:0];
         dkef_pkg::CSR_HEIGHT_ROWS:  height_reg = value[dkef_pkg::DIM_W-1:0];
         default: ;
      endcase
   endtask

   task automatic predict_edge_byte(dkef_pkg::req_payload_type beat);
      int unsigned     line;
      int unsigned     pb;
      int unsigned     wp;
      int unsigned     rows;
      int unsigned     total;
      int unsigned     lag;
      int unsigned     q;
      int unsigned     row;
      int unsigned     colb;
      int unsigned     col;
      int unsigned     p;
      int              k;
      int              v;
      int              sum_a;
      int              sum_b;
      dkef_pkg::rsp_payload_type want;
      line = clamp_dim(line_reg, MIN_LINE_BYTES, dkef_pkg::DEF_MAX_LINE_BYTES);
      pb = clamp_dim(pix_reg, 1, dkef_pkg::DEF_MAX_PIXEL_BYTES);
      wp = clamp_dim(width_reg, 1, dkef_pkg::MAX_DIM);
      rows = clamp_dim(height_reg, 1, dkef_pkg::MAX_DIM);
      if (wp > line / pb) wp = line / pb;
      total = line * rows;
      lag = line + pb;

      if (in_pos < total) begin
         if (beat.flush) return;
         byte_ring[in_pos % RING_DEPTH] = beat.data_byte;
      end
      in_pos++;
      if (in_pos - out_pos <= lag) return;

      q = out_pos;
      row = q / line;
      colb = q % line;
      col = colb / pb;
      if (row >= 1 && row + 1 < rows && colb < wp * pb && col >= 1 && col + 2 <= wp) begin
         sum_a = 0;
         sum_b = 0;
         for (k = 0; k < dkef_pkg::NUM_COEF; k++) begin
            p = q - line - pb + (k / 3) * line + (k % 3) * pb;
            v = byte_ring[p % RING_DEPTH];
            sum_a += v * tap(kern_a, k);
            sum_b += v * tap(kern_b, k);
         end
         if (sum_a < 0) sum_a = -sum_a;
         if (sum_b < 0) sum_b = -sum_b;
         want.result_byte = dkef_pkg::DATA_W'(sum_a + sum_b);
      end else begin
         want.result_byte = byte_ring[q % RING_DEPTH];
      end
      want.last_of_frame = (q + 1 >= total);
      expected_bytes.push_back(want);

      if (want.last_of_frame) begin
         in_pos = 0;
         out_pos = 0;
      end else begin
         out_pos++;
      end
   endtask

   task automatic check_result(dkef_pkg::rsp_payload_type got);
      dkef_pkg::rsp_payload_type want;
      if (expected_bytes.size() == 0) begin
         report_mismatch($sformatf("beat 0x%0h/%0b with nothing pending",
                                   got.result_byte, got.last_of_frame));
         return;
      end
      want = expected_bytes.pop_front();
      if (got.result_byte !== want.result_byte)
         report_mismatch($sformatf("result_byte 0x%0h, expected 0x%0h",
                                   got.result_byte, want.result_byte));
      if (got.last_of_frame !== want.last_of_frame)
         report_mismatch($sformatf("last_of_frame %0b, expected %0b",
                                   got.last_of_frame, want.last_of_frame));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kern_a = dkef_pkg::KERNEL_A_RESET;
         kern_b = dkef_pkg::KERNEL_B_RESET;
         line_reg = dkef_pkg::LINE_BYTES_RESET;
         pix_reg = dkef_pkg::PIXEL_BYTES_RESET;
         width_reg = dkef_pkg::WIDTH_RESET;
         height_reg = dkef_pkg::HEIGHT_RESET;
         in_pos = 0;
         out_pos = 0;
         result_beats = 0;
         expected_bytes.delete();
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && req_ready) predict_edge_byte(req_payload);
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_payload);
            result_beats++;
         end
      end
      pending_count <= expected_bytes.size();
   end

endmodule

[tb/dual_kernel_3x3_edge_filter_test.sv]
`timescale 1ns / 1ps
// dual_kernel_3x3_edge_filter_test: clock, reset, raster and register stimulus for the
// edge filter, and the verdict. Depends on dkef_pkg, the filter RTL and dkef_edge_checker.
module dual_kernel_3x3_edge_filter_test;

   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int PHASE_ITEMS    = 300;
   localparam int MIN_LINE_BYTES = 3;
   localparam int KW             = dkef_pkg::KERN_W;
   localparam int DIMW           = dkef_pkg::DIM_W;
   localparam int PBW            = dkef_pkg::PB_W;
   localparam int IXW            = dkef_pkg::CSR_IDX_W;
   localparam int BW             = dkef_pkg::DATA_W;
   localparam logic [IXW-1:0] CSR_SPARE_LOW  = IXW'(dkef_pkg::CSR_HEIGHT_ROWS + 1);
   localparam logic [IXW-1:0] CSR_SPARE_HIGH = IXW'(dkef_pkg::CSR_HEIGHT_ROWS + 2);
   localparam logic [KW-1:0] KERNEL_ALL_MIN = {dkef_pkg::NUM_COEF{4'h8}};
   localparam logic [KW-1:0] KERNEL_ALL_MAX = {dkef_pkg::NUM_COEF{4'h7}};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   dkef_pkg::req_payload_type req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   dkef_pkg::rsp_payload_type rsp_payload;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [IXW-1:0]            csr_index = '0;
   logic [KW-1:0]             csr_data = '0;
   int                        pending_count;
   int                        error_count;
   int                        send_idle_pct = 0;
   int                        stall_pct = 0;
   int                        hold_requests = 0;
   int                        holds_served = 0;
   int                        quiet_cycles = 0;
   int unsigned               frame_line;
   int unsigned               frame_pix;
   int unsigned               frame_rows;
   int unsigned               items_sent = 0;

   always #2 clock = ~clock;

   dual_kernel_3x3_edge_filter dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   dkef_edge_checker edge_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .pending_count (pending_count),
      .error_count   (error_count)
   );

   // result side: random stalls, or one long hold-off when requested
   always begin
      @(posedge clock);
      if (holds_served < hold_requests) begin
         holds_served++;
         rsp_ready <= 1'b0;
         repeat (HOLD_CYCLES) @(posedge clock);
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   task automatic write_csr(input logic [IXW-1:0] index, input logic [KW-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [KW-1:0] ka, input logic [KW-1:0] kb,
                            input logic [DIMW-1:0] line, input logic [PBW-1:0] pix,
                            input logic [DIMW-1:0] width, input logic [DIMW-1:0] height);
      write_csr(dkef_pkg::CSR_KERNEL_A, ka);
      write_csr(dkef_pkg::CSR_KERNEL_B, kb);
      write_csr(dkef_pkg::CSR_LINE_BYTES, KW'(line));
      write_csr(dkef_pkg::CSR_PIXEL_BYTES, KW'(pix));
      write_csr(dkef_pkg::CSR_WIDTH_PIXELS, KW'(width));
      write_csr(dkef_pkg::CSR_HEIGHT_ROWS, KW'(height));
      csr_valid <= 1'b0;
      frame_line = line < MIN_LINE_BYTES ? MIN_LINE_BYTES :
                   (line > dkef_pkg::DEF_MAX_LINE_BYTES ? dkef_pkg::DEF_MAX_LINE_BYTES : line);
      frame_pix = pix == 0 ? 1 :
                  (pix > dkef_pkg::DEF_MAX_PIXEL_BYTES ? dkef_pkg::DEF_MAX_PIXEL_BYTES : pix);
      frame_rows = height == 0 ? 1 : (height > dkef_pkg::MAX_DIM ? dkef_pkg::MAX_DIM : height);
   endtask

   task automatic send_beat(input logic [BW-1:0] value, input logic is_flush);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{data_byte: value, flush: is_flush};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (dkef_pkg::PIPE_STAGES + 4) @(posedge clock);
   endtask

   function automatic logic [BW-1:0] random_byte();
      if ($urandom_range(9) == 0) return $urandom_range(1) ? '1 : '0;
      return BW'($urandom_range(255));
   endfunction

   function automatic logic [KW-1:0] random_kernel();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      case ($urandom_range(7))
         0: return KERNEL_ALL_MIN;
         1: return KERNEL_ALL_MAX;
         2: return '0;
         3: return dkef_pkg::KERNEL_B_RESET;
         default: return bits[KW-1:0];
      endcase
   endfunction

   // raster bytes, then the tail that pushes the frame out; noisy adds ignored flushes
   task automatic send_frame(input bit noisy);
      int unsigned i;
      for (i = 0; i < frame_line * frame_rows; i++) begin
         if (noisy && $urandom_range(99) < 3) send_beat(random_byte(), 1'b1);
         send_beat(random_byte(), 1'b0);
      end
      for (i = 0; i < frame_line + frame_pix; i++)
         send_beat(random_byte(), $urandom_range(99) >= 15);
      items_sent += frame_line * frame_rows + frame_line + frame_pix;
      if (noisy && $urandom_range(99) < 20) send_beat(random_byte(), 1'b1);
   endtask

   task automatic random_setup();
      logic [DIMW-1:0] line;
      logic [DIMW-1:0] width;
      logic [DIMW-1:0] height;
      logic [PBW-1:0]  pix;
      int unsigned     row_pixels;
      line = DIMW'($urandom_range(24));
      pix = PBW'($urandom_range(7));
      row_pixels = (line < MIN_LINE_BYTES ? MIN_LINE_BYTES : line) /
                   (pix == 0 ? 1 :
                    (pix > dkef_pkg::DEF_MAX_PIXEL_BYTES ? dkef_pkg::DEF_MAX_PIXEL_BYTES : pix));
      case ($urandom_range(9))
         0: width = '0;
         1: width = '1;
         default: width = DIMW'($urandom_range(row_pixels + 1, 1));
      endcase
      height = DIMW'($urandom_range(7));
      wait_idle();
      configure(random_kernel(), random_kernel(), line, pix, width, height);
   endtask

   // 5-byte stride, 4-pixel rows, 3 rows: one padding column, dark top, bright bottom
   task automatic directed_frame();
      int unsigned i;
      configure(dkef_pkg::KERNEL_A_RESET, dkef_pkg::KERNEL_B_RESET,
                13'd5, 3'd1, 13'd4, 13'd3);
      for (i = 0; i < frame_line * frame_rows; i++) begin
         if (i == 7) send_beat(8'h3C, 1'b1);
         send_beat(i < 7 ? 8'h00 : 8'hFF, 1'b0);
      end
      send_beat(8'hA5, 1'b0);
      for (i = 1; i < frame_line + frame_pix; i++) send_beat(8'h00, 1'b1);
      items_sent += frame_line * frame_rows + frame_line + frame_pix;
   endtask

   initial begin
      int          phase;
      int unsigned phase_end;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      directed_frame();

      // long result hold-off while the raster keeps coming
      wait_idle();
      configure(random_kernel(), random_kernel(), 13'd16, 3'd1, 13'd16, 13'd8);
      hold_requests <= hold_requests + 1;
      send_frame(1'b0);

      wait_idle();
      write_csr(CSR_SPARE_LOW, random_kernel());
      write_csr(CSR_SPARE_HIGH, random_kernel());
      csr_valid <= 1'b0;

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct <= 0;  end
            1: begin send_idle_pct = 55; stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  stall_pct <= 55; end
            default: begin send_idle_pct = 12; stall_pct <= 12; end
         endcase
         phase_end = items_sent + PHASE_ITEMS;
         while (items_sent < phase_end) begin
            random_setup();
            repeat ($urandom_range(2, 1)) send_frame(1'b1);
         end
      end

      // pixel and width registers at their top codes, row width clipped to the stride
      send_idle_pct = 0;
      stall_pct <= 0;
      wait_idle();
      configure(random_kernel(), random_kernel(), 13'd40, '1, '1, 13'd3);
      send_frame(1'b1);
      wait_idle();

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[files.f]
src/dkef_pkg.sv
src/dkef_line_buffer.sv
src/dkef_kernel_mac.sv
src/dkef_rsp_fifo.sv
src/dual_kernel_3x3_edge_filter.sv
src/dkef_checker.sv
tb/dkef_edge_checker.sv
tb/dual_kernel_3x3_edge_filter_test.sv
